/* hdl/drp_pkg.sv */
// drp_pkg: shared types, register map and scaling constants of the drive parameter register file
// depends on nothing; used by drp_front, drp_queue and drp_back
package drp_pkg;

    typedef enum logic [3:0] {
        OP_ENABLE,
        OP_TORQUE,
        OP_FREQ,
        OP_FLAG,
        OP_PROG,
        OP_ARM,
        OP_CURVE,
        OP_RESET,
        OP_BUS,
        OP_MOTOR,
        OP_CTRL_LO,
        OP_TIMEOUT,
        OP_CTRL_HI,
        OP_TABLE,
        OP_UNKNOWN
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] addr;
        logic [15:0] value;
    } entry_t;

    localparam int Q_DEPTH = 4;

    localparam logic [15:0] ADDR_ENABLE   = 16'd40100;
    localparam logic [15:0] ADDR_TORQUE   = 16'd40101;
    localparam logic [15:0] ADDR_FREQ     = 16'd40102;
    localparam logic [15:0] ADDR_FLAG_LO  = 16'd40103;
    localparam logic [15:0] ADDR_FLAG_HI  = 16'd40105;
    localparam logic [15:0] ADDR_PROG     = 16'd40110;
    localparam logic [15:0] ADDR_ARM      = 16'd40111;
    localparam logic [15:0] ADDR_CURVE    = 16'd40120;
    localparam logic [15:0] ADDR_RESET    = 16'd40150;
    localparam logic [15:0] ADDR_BUS_ID   = 16'd40300;
    localparam logic [15:0] ADDR_BAUD_HI  = 16'd40301;
    localparam logic [15:0] ADDR_BAUD_LO  = 16'd40302;
    localparam logic [15:0] ADDR_PARITY   = 16'd40303;
    localparam logic [15:0] ADDR_OFFSET   = 16'd40304;
    localparam logic [15:0] ADDR_MOTOR_LO = 16'd40400;
    localparam logic [15:0] ADDR_MOTOR_HI = 16'd40407;
    localparam logic [15:0] ADDR_CTRL_LO  = 16'd40500;
    localparam logic [15:0] ADDR_CTRL_MID = 16'd40503;
    localparam logic [15:0] ADDR_TOUT_LO  = 16'd40504;
    localparam logic [15:0] ADDR_TOUT_HI  = 16'd40531;
    localparam logic [15:0] ADDR_CTRL_HI  = 16'd40532;
    localparam logic [15:0] ADDR_CURR_SEL = 16'd40541;
    localparam logic [15:0] ADDR_CTRL_END = 16'd40543;

    localparam logic [15:0] CURR_SEL_LIM  = 16'd5;
    localparam logic [15:0] LAST_LIM      = 16'd4;
    localparam logic [15:0] BUS_ID_LIM    = 16'd248;
    localparam logic [15:0] PARITY_LIM    = 16'd3;
    localparam logic signed [15:0] TORQUE_MAX = 16'sd100;
    localparam logic signed [15:0] TORQUE_MIN = -16'sd100;

    // 1.10 * 1774 taken exactly as 19514/10, with the /2048 folded in
    localparam logic [14:0] DC_MUL  = 15'd19514;
    // /20480 done as >> 12 then /5 by reciprocal, ceil(2^22 / 5)
    localparam logic [19:0] DC_RECIP = 20'd838861;
    localparam logic [10:0] NOM_K   = 11'd1448;
    localparam logic [10:0] MIN_K   = 11'd1774;

    function automatic logic [7:0] clamp255(input logic [63:0] v);
        clamp255 = (v > 64'd255) ? 8'hFF : v[7:0];
    endfunction

endpackage

/* hdl/drp_front.sv */
// drp_front: decodes the register address of each write beat into an operation class
// depends on drp_pkg
module drp_front #(
    parameter int TABLE_DEPTH     = 2048,
    parameter int TABLE_BASE_ADDR = 41000
) (
    input  logic                push,
    output logic                full,
    input  logic [15:0]         reg_address,
    input  logic [15:0]         reg_value,
    input  logic                q_full,
    output logic                q_push,
    output drp_pkg::entry_t     q_entry
);

    localparam logic [16:0] TBL_LO = 17'(TABLE_BASE_ADDR);
    localparam logic [16:0] TBL_HI = 17'(TABLE_BASE_ADDR + TABLE_DEPTH);

    drp_pkg::op_t op;
    logic [16:0]  a17;

    assign a17 = {1'b0, reg_address};

    always_comb
    begin
        if (reg_address == drp_pkg::ADDR_ENABLE)
            op = drp_pkg::OP_ENABLE;
        else if (reg_address == drp_pkg::ADDR_TORQUE)
            op = drp_pkg::OP_TORQUE;
        else if (reg_address == drp_pkg::ADDR_FREQ)
            op = drp_pkg::OP_FREQ;
        else if (reg_address >= drp_pkg::ADDR_FLAG_LO && reg_address <= drp_pkg::ADDR_FLAG_HI)
            op = drp_pkg::OP_FLAG;
        else if (reg_address == drp_pkg::ADDR_PROG)
            op = drp_pkg::OP_PROG;
        else if (reg_address == drp_pkg::ADDR_ARM)
            op = drp_pkg::OP_ARM;
        else if (reg_address == drp_pkg::ADDR_CURVE)
            op = drp_pkg::OP_CURVE;
        else if (reg_address == drp_pkg::ADDR_RESET)
            op = drp_pkg::OP_RESET;
        else if (reg_address >= drp_pkg::ADDR_BUS_ID && reg_address <= drp_pkg::ADDR_OFFSET)
            op = drp_pkg::OP_BUS;
        else if (reg_address >= drp_pkg::ADDR_MOTOR_LO && reg_address <= drp_pkg::ADDR_MOTOR_HI)
            op = drp_pkg::OP_MOTOR;
        else if (reg_address >= drp_pkg::ADDR_CTRL_LO && reg_address <= drp_pkg::ADDR_CTRL_MID)
            op = drp_pkg::OP_CTRL_LO;
        else if (reg_address >= drp_pkg::ADDR_TOUT_LO && reg_address <= drp_pkg::ADDR_TOUT_HI)
            op = drp_pkg::OP_TIMEOUT;
        else if (reg_address >= drp_pkg::ADDR_CTRL_HI && reg_address <= drp_pkg::ADDR_CTRL_END)
            op = drp_pkg::OP_CTRL_HI;
        else if (a17 >= TBL_LO && a17 < TBL_HI)
            op = drp_pkg::OP_TABLE;
        else
            op = drp_pkg::OP_UNKNOWN;
    end

    assign full          = q_full;
    assign q_push        = push && !q_full;
    assign q_entry.op    = op;
    assign q_entry.addr  = reg_address;
    assign q_entry.value = reg_value;

endmodule

/* hdl/drp_queue.sv */
// drp_queue: short fifo of decoded write beats between front and back
// depends on drp_pkg
module drp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  drp_pkg::entry_t wr_data,
    output logic            q_full,
    input  logic            rd_en,
    output drp_pkg::entry_t rd_data,
    output logic            q_empty
);

    localparam int PW = $clog2(drp_pkg::Q_DEPTH);

    drp_pkg::entry_t mem_reg [drp_pkg::Q_DEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [PW:0]     cnt_reg;

    assign q_full  = (cnt_reg == (PW+1)'(drp_pkg::Q_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

/* hdl/drp_div.sv */
// drp_div: 64-bit unsigned restoring divider, one quotient bit per cycle
// depends on nothing; a zero divisor returns all ones
module drp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quo
);

    logic [63:0] rem_reg, quo_reg, den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [64:0] shifted, trial;
    logic        ge;

    assign shifted = {rem_reg, quo_reg[63]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign trial   = shifted - {1'b0, den_reg};
    assign done    = done_reg;
    assign quo     = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= (den == '0) ? '1 : num;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial[63:0] : shifted[63:0];
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= (den != '0);
                done_reg <= (den == '0);
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* hdl/drp_back.sv */
// drp_back: executes decoded writes, holds setpoints, parameters and the v/f table,
// runs the curve rebuild sequencer; depends on drp_pkg and drp_div
module drp_back #(
    parameter int TABLE_DEPTH     = 2048,
    parameter int TABLE_BASE_ADDR = 41000
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  drp_pkg::entry_t    q_entry,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic               status,
    output logic               save_request,
    output logic               reset_request,
    output logic signed [1:0]  enable_now,
    output logic signed [7:0]  torque_now,
    output logic [15:0]        frequency_now,
    output logic               programming_now
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam logic [15:0] TOP_IDX = 16'(TABLE_DEPTH - 1);
    localparam logic [15:0] TBL_BASE = 16'(TABLE_BASE_ADDR);

    typedef enum logic [13:0] {
        ST_IDLE     = 14'b00000000000001,
        ST_DC_MUL   = 14'b00000000000010,
        ST_DC_DIV   = 14'b00000000000100,
        ST_M_MUL    = 14'b00000000001000,
        ST_M_DIV    = 14'b00000000010000,
        ST_FILL     = 14'b00000000100000,
        ST_FILL_DIV = 14'b00000001000000,
        ST_S_MUL    = 14'b00000010000000,
        ST_S_DIV    = 14'b00000100000000,
        ST_F_RD     = 14'b00001000000000,
        ST_F_WAIT   = 14'b00010000000000,
        ST_RAMP     = 14'b00100000000000,
        ST_RAMP_DIV = 14'b01000000000000,
        ST_DONE     = 14'b10000000000000
    } state_t;

    state_t state_reg;

    // run and mode state
    logic signed [1:0] enable_reg;
    logic signed [7:0] torque_reg;
    logic [15:0]       freq_reg;
    logic [2:0]        flags_reg;
    logic              prog_reg, armed_reg;
    // parameters
    logic [7:0]        bus_id_reg;
    logic [31:0]       baud_reg;
    logic [1:0]        parity_reg;
    logic [15:0]       offset_reg;
    logic [15:0]       motor_reg [8];
    logic [15:0]       ctrl_reg [16];
    logic [63:0]       tout_reg [7];
    // table
    logic [7:0]        tbl_mem [TABLE_DEPTH];
    logic [7:0]        tbl_rd_reg;
    logic              tbl_we;
    logic [IW-1:0]     tbl_wa;
    logic [7:0]        tbl_wd;
    // result register
    logic              out_valid_reg, status_reg, save_reg, rst_req_reg;
    logic signed [1:0] en_out_reg;
    logic signed [7:0] tq_out_reg;
    logic [15:0]       fr_out_reg;
    logic              pm_out_reg;
    // rebuild
    logic [63:0]       num_reg, den_reg, acc_reg, m_reg, s_reg, diff_reg;
    logic [15:0]       dc_reg;
    logic [IW-1:0]     i_reg, b_reg;
    logic              div_start_reg, div_done;
    logic [63:0]       div_quo;
    logic [38:0]       dc_prod;

    logic              out_free, exec, rebuild;
    logic              pm, v_one;
    logic signed [15:0] sv;
    logic [15:0]       v, lim, off;
    logic signed [1:0] en_next;
    logic signed [7:0] tq_next;
    logic [15:0]       fr_next;
    logic              pm_next, save_c, rst_c, status_c;
    logic [26:0]       mnv_prod, mmv_prod;
    logic [16:0]       mnv_sc, mmv_sc;
    logic [15:0]       b_full;

    drp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign out_free = !out_valid_reg || pop;
    assign exec     = (state_reg == ST_IDLE) && !q_empty && out_free;
    assign q_pop    = exec;
    assign v        = q_entry.value;
    assign sv       = signed'(q_entry.value);
    assign pm       = prog_reg;
    assign v_one    = (v == 16'd1);
    assign rebuild  = (q_entry.op == drp_pkg::OP_CURVE) && pm && v_one;
    assign lim      = flags_reg[2] ? ctrl_reg[1] : ctrl_reg[0];

    always_comb
    begin
        en_next  = enable_reg;
        tq_next  = torque_reg;
        fr_next  = freq_reg;
        pm_next  = prog_reg;
        save_c   = 1'b0;
        rst_c    = 1'b0;
        status_c = 1'b0;
        off      = '0;
        unique case (q_entry.op)
            drp_pkg::OP_ENABLE: en_next = (!pm && v_one) ? 2'sd1 : -2'sd1;
            drp_pkg::OP_TORQUE:
            begin
                if (sv > drp_pkg::TORQUE_MAX)
                    tq_next = 8'(drp_pkg::TORQUE_MAX);
                else if (sv < drp_pkg::TORQUE_MIN)
                    tq_next = 8'(drp_pkg::TORQUE_MIN);
                else
                    tq_next = sv[7:0];
            end
            drp_pkg::OP_FREQ:   fr_next = (v > lim) ? lim : v;
            drp_pkg::OP_PROG:
            begin
                if (!pm && v_one)
                begin
                    en_next = -2'sd1;
                    pm_next = 1'b1;
                end
                else if (pm && !v_one && armed_reg)
                    save_c = 1'b1;
                else
                    pm_next = 1'b0;
            end
            drp_pkg::OP_RESET:  rst_c = pm && v_one;
            drp_pkg::OP_FLAG:   off = q_entry.addr - drp_pkg::ADDR_FLAG_LO;
            drp_pkg::OP_MOTOR:  off = q_entry.addr - drp_pkg::ADDR_MOTOR_LO;
            drp_pkg::OP_CTRL_LO: off = q_entry.addr - drp_pkg::ADDR_CTRL_LO;
            drp_pkg::OP_TIMEOUT: off = q_entry.addr - drp_pkg::ADDR_TOUT_LO;
            // upper controller words sit from slot four on
            drp_pkg::OP_CTRL_HI: off = q_entry.addr - drp_pkg::ADDR_CTRL_HI + 16'd4;
            drp_pkg::OP_TABLE:  off = q_entry.addr - TBL_BASE;
            drp_pkg::OP_ARM,
            drp_pkg::OP_CURVE,
            drp_pkg::OP_BUS:    ;
            default:            status_c = 1'b1;
        endcase
    end

    assign mnv_prod = 27'(motor_reg[0] * drp_pkg::NOM_K);
    assign mmv_prod = 27'(motor_reg[1] * drp_pkg::MIN_K);
    assign mnv_sc   = mnv_prod[26:10];
    assign mmv_sc   = mmv_prod[26:10];
    assign b_full   = {5'b0, motor_reg[3][15:5]};
    assign dc_prod  = num_reg[30:12] * drp_pkg::DC_RECIP;

    // single table write port shared by direct writes and the rebuild
    always_comb
    begin
        tbl_we = 1'b0;
        tbl_wa = i_reg;
        tbl_wd = drp_pkg::clamp255(div_quo);
        if (exec && q_entry.op == drp_pkg::OP_TABLE)
        begin
            tbl_we = 1'b1;
            tbl_wa = off[IW-1:0];
            tbl_wd = v[7:0];
        end
        else if (state_reg == ST_FILL_DIV && div_done)
            tbl_we = 1'b1;
        else if (state_reg == ST_RAMP_DIV && div_done)
        begin
            tbl_we = 1'b1;
            tbl_wd = drp_pkg::clamp255(s_reg + div_quo);
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[tbl_wa] <= tbl_wd;
        tbl_rd_reg <= tbl_mem[b_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enable_reg    <= -2'sd1;
            torque_reg    <= '0;
            freq_reg      <= '0;
            flags_reg     <= '0;
            prog_reg      <= 1'b0;
            armed_reg     <= 1'b0;
            bus_id_reg    <= '0;
            baud_reg      <= '0;
            parity_reg    <= '0;
            offset_reg    <= '0;
            for (int k = 0; k < 8; k++)
                motor_reg[k] <= '0;
            for (int k = 0; k < 16; k++)
                ctrl_reg[k] <= '0;
            for (int k = 0; k < 7; k++)
                tout_reg[k] <= '0;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (exec)
                    begin
                        enable_reg <= en_next;
                        torque_reg <= tq_next;
                        freq_reg   <= fr_next;
                        prog_reg   <= pm_next;
                        case (q_entry.op)
                            drp_pkg::OP_FLAG:   flags_reg[off[1:0]] <= v_one;
                            drp_pkg::OP_ARM:    if (pm) armed_reg <= v_one;
                            drp_pkg::OP_BUS:
                            begin
                                if (pm)
                                begin
                                    if (q_entry.addr == drp_pkg::ADDR_BUS_ID)
                                    begin
                                        if (v != '0 && v < drp_pkg::BUS_ID_LIM)
                                            bus_id_reg <= v[7:0];
                                    end
                                    else if (q_entry.addr == drp_pkg::ADDR_BAUD_HI)
                                        baud_reg[31:16] <= v;
                                    else if (q_entry.addr == drp_pkg::ADDR_BAUD_LO)
                                        baud_reg[15:0] <= v;
                                    else if (q_entry.addr == drp_pkg::ADDR_PARITY)
                                    begin
                                        if (v < drp_pkg::PARITY_LIM)
                                            parity_reg <= v[1:0];
                                    end
                                    else if (sv > -16'sd2 && sv < 16'sd2)
                                        offset_reg <= v;
                                end
                            end
                            drp_pkg::OP_MOTOR:  if (pm) motor_reg[off[2:0]] <= v;
                            drp_pkg::OP_CTRL_LO: if (pm) ctrl_reg[off[3:0]] <= v;
                            drp_pkg::OP_TIMEOUT:
                                if (pm) tout_reg[off[4:2]][{~off[1:0], 4'b0} +: 16] <= v;
                            drp_pkg::OP_CTRL_HI:
                                if (pm
                                    && !(q_entry.addr == drp_pkg::ADDR_CURR_SEL
                                         && v >= drp_pkg::CURR_SEL_LIM)
                                    && !(q_entry.addr == drp_pkg::ADDR_CTRL_END
                                         && v >= drp_pkg::LAST_LIM))
                                    ctrl_reg[off[3:0]] <= v;
                            default: ;
                        endcase
                        if (rebuild)
                            state_reg <= ST_DC_MUL;
                        else
                        begin
                            out_valid_reg <= 1'b1;
                            status_reg    <= status_c;
                            save_reg      <= save_c;
                            rst_req_reg   <= rst_c;
                            en_out_reg    <= en_next;
                            tq_out_reg    <= tq_next;
                            fr_out_reg    <= fr_next;
                            pm_out_reg    <= pm_next;
                        end
                    end
                end
                ST_DC_MUL:
                begin
                    num_reg       <= 64'(ctrl_reg[4] * drp_pkg::DC_MUL);
                    b_reg         <= (b_full > TOP_IDX) ? TOP_IDX[IW-1:0] : b_full[IW-1:0];
                    state_reg     <= ST_DC_DIV;
                end
                ST_DC_DIV:
                begin
                    dc_reg    <= dc_prod[37:22];
                    state_reg <= ST_M_MUL;
                end
                ST_M_MUL:
                begin
                    // x * 255 as x * 256 - x
                    num_reg       <= {39'b0, mnv_sc, 8'b0} - {47'b0, mnv_sc};
                    den_reg       <= {48'b0, dc_reg};
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_M_DIV;
                end
                ST_M_DIV:
                    if (div_done)
                    begin
                        m_reg     <= div_quo;
                        acc_reg   <= '0;
                        i_reg     <= '0;
                        state_reg <= ST_FILL;
                    end
                ST_FILL:
                begin
                    num_reg       <= acc_reg;
                    den_reg       <= {53'b0, motor_reg[2][15:5]};
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_FILL_DIV;
                end
                ST_FILL_DIV:
                    if (div_done)
                    begin
                        acc_reg <= acc_reg + m_reg;
                        i_reg   <= i_reg + 1'b1;
                        state_reg <= (i_reg == TOP_IDX[IW-1:0]) ? ST_S_MUL : ST_FILL;
                    end
                ST_S_MUL:
                begin
                    num_reg       <= {39'b0, mmv_sc, 8'b0} - {47'b0, mmv_sc};
                    den_reg       <= {48'b0, dc_reg};
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_S_DIV;
                end
                ST_S_DIV:
                    if (div_done)
                    begin
                        s_reg     <= div_quo;
                        state_reg <= ST_F_RD;
                    end
                ST_F_RD:
                    state_reg <= ST_F_WAIT;
                ST_F_WAIT:
                begin
                    diff_reg  <= {56'b0, tbl_rd_reg} - s_reg;
                    acc_reg   <= '0;
                    i_reg     <= '0;
                    state_reg <= ST_RAMP;
                end
                ST_RAMP:
                begin
                    num_reg       <= acc_reg;
                    den_reg       <= 64'(b_reg);
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_RAMP_DIV;
                end
                ST_RAMP_DIV:
                    if (div_done)
                    begin
                        acc_reg <= acc_reg + diff_reg;
                        i_reg   <= i_reg + 1'b1;
                        state_reg <= (i_reg == b_reg) ? ST_DONE : ST_RAMP;
                    end
                ST_DONE:
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= 1'b0;
                        save_reg      <= 1'b0;
                        rst_req_reg   <= 1'b0;
                        en_out_reg    <= enable_reg;
                        tq_out_reg    <= torque_reg;
                        fr_out_reg    <= freq_reg;
                        pm_out_reg    <= prog_reg;
                        state_reg     <= ST_IDLE;
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign empty           = !out_valid_reg;
    assign status          = status_reg;
    assign save_request    = save_reg;
    assign reset_request   = rst_req_reg;
    assign enable_now      = en_out_reg;
    assign torque_now      = tq_out_reg;
    assign frequency_now   = fr_out_reg;
    assign programming_now = pm_out_reg;

    // programming mode is only left through a mode write
    a_prog_exit: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(prog_reg) |-> $past(exec && q_entry.op == drp_pkg::OP_PROG))
        else $error("programming mode left outside a mode write");

    // the drive cannot be enabled while in programming mode
    a_enable_prog: assert property (@(posedge clk) disable iff (!rst_n)
        enable_reg == 2'sd1 |-> !prog_reg)
        else $error("drive enabled in programming mode");

    a_torque_range: assert property (@(posedge clk) disable iff (!rst_n)
        torque_reg <= 8'sd100 && torque_reg >= -8'sd100)
        else $error("torque setpoint out of range");

    // nothing leaves the queue while a rebuild runs
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !q_pop)
        else $error("queue popped during rebuild");

endmodule

/* hdl/drive_parameter_register_file_top.sv */
// drive_parameter_register_file_top: holding-register write file of a motor drive
// Writes enter on a queue-style input (push/full) and results leave on a
// queue-style output (empty/pop). One beat in gives exactly one result beat out.
// A front decoder classifies the address, a four-deep queue holds decoded beats,
// and the back end executes them one at a time against the register state.
// An ordinary write on an idle block passes the queue and then the result register before
// its result shows; the back end takes one beat per cycle while the result register is free.
// A curve rebuild write puts every table entry through the 64-bit serial divider,
// and the entries of the boost ramp span go through it a second time.
// When the receiver does not pop, the result register holds and the queue
// fills, after which full stays high. Reset sets enable to disabled, clears
// the setpoints, mode flags and parameters; the table needs no clearing pass
// since a rebuild overwrites it before it is read.
module drive_parameter_register_file_top #(
    parameter int TABLE_DEPTH     = 2048,
    parameter int TABLE_BASE_ADDR = 41000
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [15:0]       reg_address,
    input  logic [15:0]       reg_value,
    output logic              empty,
    input  logic              pop,
    output logic              status,
    output logic              save_request,
    output logic              reset_request,
    output logic signed [1:0] enable_now,
    output logic signed [7:0] torque_now,
    output logic [15:0]       frequency_now,
    output logic              programming_now
);

    drp_pkg::entry_t wr_entry, rd_entry;
    logic            q_full, q_push, q_empty, q_pop;

    drp_front #(
        .TABLE_DEPTH     (TABLE_DEPTH),
        .TABLE_BASE_ADDR (TABLE_BASE_ADDR)
    ) u_front (
        .push        (push),
        .full        (full),
        .reg_address (reg_address),
        .reg_value   (reg_value),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (wr_entry)
    );

    drp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (wr_entry),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (rd_entry),
        .q_empty (q_empty)
    );

    drp_back #(
        .TABLE_DEPTH     (TABLE_DEPTH),
        .TABLE_BASE_ADDR (TABLE_BASE_ADDR)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_entry         (rd_entry),
        .q_pop           (q_pop),
        .pop             (pop),
        .empty           (empty),
        .status          (status),
        .save_request    (save_request),
        .reset_request   (reset_request),
        .enable_now      (enable_now),
        .torque_now      (torque_now),
        .frequency_now   (frequency_now),
        .programming_now (programming_now)
    );

endmodule
